// ===== hw/rtl/htc_pkg.sv =====
`timescale 1ns / 1ps

package htc_pkg;

  localparam int TicksW = 14;
  localparam int HumiW  = 12;
  localparam int CentiW = 14;

  localparam logic signed [15:0] TEMP_OFFSET = 16'sd4010;
  localparam logic signed [15:0] TEMP_MAX    = 16'sd10000;
  localparam logic signed [15:0] TEMP_REF    = 16'sd2500;

  localparam logic signed [43:0] HUMI_C1 = -44'sd20468000000;
  localparam logic [28:0]        HUMI_C2 = 29'd367000000;
  localparam logic [13:0]        HUMI_C3 = 14'd15955;
  localparam logic [19:0]        HUMI_T1 = 20'd1000000;
  localparam logic [12:0]        HUMI_T2 = 13'd8000;

  // q < 10 and q > 10000 thresholds on H, in 1e-10 %RH
  localparam logic signed [43:0] HUMI_LO_LIM = 44'sd1000000000;
  localparam logic signed [43:0] HUMI_HI_LIM = 44'sd1000100000000;

  // 1e8 = 2^8 * 390625; x / 390625 ~ (x * RECIP_M) >> RECIP_SHIFT, never above
  localparam logic [18:0] DIV_ODD     = 19'd390625;
  localparam logic [25:0] RECIP_M     = 26'd45035996;
  localparam int          RecipShift  = 44;

  localparam logic [CentiW-1:0] HUMI_MIN = 14'd10;
  localparam logic [CentiW-1:0] HUMI_MAX = 14'd10000;

  typedef struct packed {
    logic              in_range;
    logic [CentiW-1:0] tc;
  } side_t;

endpackage

// ===== hw/rtl/humidity_temperature_conversion_unit.sv =====
`timescale 1ns / 1ps

// Humidity linearization with temperature compensation.
// Request channel: temp_ticks (14 bit) and humi_ticks (12 bit) are taken at a
// rising edge where start is high and busy is low. busy is held low: the
// pipeline takes one request every cycle, with no gaps.
// Result channel: done is high for one cycle with in_range, temp_centi and
// humi_centi; the receiver cannot stall and must take it in that cycle.
// temp_centi = temp_ticks - 4010 in 0.01 degC; humi_centi is the compensated
// humidity in 0.01 %RH, clamped to 10..10000. When in_range is low both
// fields are zero.
// Pipeline: seven register stages (products, second products, wide sum,
// limit check, reciprocal multiply, back multiply, correction and clamp).
// Throughput: one result per cycle, set by the multiplier stages.
// Reset: rst (synchronous) clears the valid bits of every stage, dropping
// requests in flight; no result follows for them.
module humidity_temperature_conversion_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [htc_pkg::TicksW-1:0] temp_ticks,
  input  logic [htc_pkg::HumiW-1:0]  humi_ticks,
  output logic                       done,
  output logic                       in_range,
  output logic [htc_pkg::CentiW-1:0] temp_centi,
  output logic [htc_pkg::CentiW-1:0] humi_centi
);

  localparam int Depth = 7;

  logic [Depth-1:0] vld;

  // stage 1 inputs
  logic signed [15:0] tc_full;
  logic signed [15:0] tcd_next;
  htc_pkg::side_t     side_next;

  // stage 1
  htc_pkg::side_t     s1_side;
  logic signed [15:0] s1_tcd;
  logic [23:0]        s1_rh2;
  logic [40:0]        s1_c2rh;
  logic [25:0]        s1_slope;

  // stage 2
  logic signed [41:0] tcd_ext;
  logic signed [41:0] slope_ext;
  htc_pkg::side_t     s2_side;
  logic [40:0]        s2_c2rh;
  logic [37:0]        s2_c3term;
  logic signed [41:0] s2_tterm;

  // stage 3
  htc_pkg::side_t     s3_side;
  logic signed [43:0] s3_h;

  // stage 4
  htc_pkg::side_t     s4_side;
  logic               s4_lo;
  logic               s4_hi;
  logic [31:0]        s4_x;

  // stage 5
  logic [57:0]        prod_next;
  htc_pkg::side_t     s5_side;
  logic               s5_lo;
  logic               s5_hi;
  logic [31:0]        s5_x;
  logic [13:0]        s5_q0;

  // stage 6
  htc_pkg::side_t     s6_side;
  logic               s6_lo;
  logic               s6_hi;
  logic [31:0]        s6_x;
  logic [13:0]        s6_q0;
  logic [33:0]        s6_qm;

  // stage 7
  logic               corr;
  logic [13:0]        q_next;
  logic [htc_pkg::CentiW-1:0] humi_next;

  assign busy = 1'b0;
  assign done = vld[Depth-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[Depth-2:0], start && !busy};
    end
  end

  always_comb begin
    tc_full            = $signed({2'b00, temp_ticks}) - htc_pkg::TEMP_OFFSET;
    tcd_next           = tc_full - htc_pkg::TEMP_REF;
    side_next.in_range = (tc_full >= 16'sd0) && (tc_full <= htc_pkg::TEMP_MAX);
    side_next.tc       = tc_full[htc_pkg::CentiW-1:0];
  end

  always_ff @(posedge clk) begin
    s1_side  <= side_next;
    s1_tcd   <= tcd_next;
    s1_rh2   <= 24'(humi_ticks) * 24'(humi_ticks);
    s1_c2rh  <= 41'(htc_pkg::HUMI_C2) * 41'(humi_ticks);
    s1_slope <= 26'(htc_pkg::HUMI_T1) + 26'(htc_pkg::HUMI_T2) * 26'(humi_ticks);
  end

  assign tcd_ext   = 42'(s1_tcd);
  assign slope_ext = $signed(42'(s1_slope));

  always_ff @(posedge clk) begin
    s2_side   <= s1_side;
    s2_c2rh   <= s1_c2rh;
    s2_c3term <= 38'(htc_pkg::HUMI_C3) * 38'(s1_rh2);
    s2_tterm  <= tcd_ext * slope_ext;
  end

  always_ff @(posedge clk) begin
    s3_side <= s2_side;
    s3_h    <= htc_pkg::HUMI_C1 + $signed(44'(s2_c2rh)) - $signed(44'(s2_c3term))
               + 44'(s2_tterm);
  end

  always_ff @(posedge clk) begin
    s4_side <= s3_side;
    s4_lo   <= s3_h < htc_pkg::HUMI_LO_LIM;
    s4_hi   <= s3_h >= htc_pkg::HUMI_HI_LIM;
    s4_x    <= s3_h[39:8];
  end

  assign prod_next = 58'(s4_x) * 58'(htc_pkg::RECIP_M);

  always_ff @(posedge clk) begin
    s5_side <= s4_side;
    s5_lo   <= s4_lo;
    s5_hi   <= s4_hi;
    s5_x    <= s4_x;
    s5_q0   <= prod_next[htc_pkg::RecipShift +: 14];
  end

  always_ff @(posedge clk) begin
    s6_side <= s5_side;
    s6_lo   <= s5_lo;
    s6_hi   <= s5_hi;
    s6_x    <= s5_x;
    s6_q0   <= s5_q0;
    s6_qm   <= 34'(s5_q0) * 34'(htc_pkg::DIV_ODD);
  end

  // estimate is low by at most one
  always_comb begin
    corr   = 34'(s6_x) >= (s6_qm + 34'(htc_pkg::DIV_ODD));
    q_next = s6_q0 + 14'(corr);
    if (!s6_side.in_range) begin
      humi_next = '0;
    end else if (s6_lo) begin
      humi_next = htc_pkg::HUMI_MIN;
    end else if (s6_hi) begin
      humi_next = htc_pkg::HUMI_MAX;
    end else begin
      humi_next = q_next;
    end
  end

  always_ff @(posedge clk) begin
    in_range   <= s6_side.in_range;
    temp_centi <= s6_side.in_range ? s6_side.tc : '0;
    humi_centi <= humi_next;
  end

`ifndef SYNTHESIS
  a_done_has_request: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, Depth))
    else $error("result without a request seven cycles earlier");

  a_out_of_range_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !in_range) |-> (temp_centi == '0 && humi_centi == '0))
    else $error("out-of-range result has nonzero fields");

  a_in_range_limits: assert property (@(posedge clk) disable iff (rst)
    (done && in_range) |-> (humi_centi >= htc_pkg::HUMI_MIN
                            && humi_centi <= htc_pkg::HUMI_MAX
                            && temp_centi <= 14'(htc_pkg::TEMP_MAX)))
    else $error("in-range result outside limits");

  a_recip_no_overshoot: assert property (@(posedge clk) disable iff (rst)
    (vld[Depth-2] && s6_side.in_range && !s6_lo && !s6_hi) |-> (34'(s6_x) >= s6_qm))
    else $error("reciprocal estimate above true quotient");
`endif

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  localparam int           TicksW      = htc_pkg::TicksW;
  localparam int           HumiW       = htc_pkg::HumiW;
  localparam int           CentiW      = htc_pkg::CentiW;

  localparam int           CycleLimit  = 200000;
  localparam int           DrainCycles = 12;
  localparam longint       TicksOffset = 4010;
  localparam longint       TcMax       = 10000;
  localparam longint       TcPivot     = 2500;
  localparam longint       RhBase      = -64'sd20468000000;
  localparam longint       RhLinear    = 367000000;
  localparam longint       RhSquare    = 15955;
  localparam longint       CompBase    = 1000000;
  localparam longint       CompSlope   = 8000;
  localparam longint       CentiScale  = 100000000;
  localparam longint       HumiFloor   = 10;
  localparam longint       HumiCeil    = 10000;

  typedef struct packed {
    logic              in_range;
    logic [CentiW-1:0] temp_centi;
    logic [CentiW-1:0] humi_centi;
  } reading_t;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  logic [TicksW-1:0] temp_ticks;
  logic [HumiW-1:0]  humi_ticks;
  logic              done;
  logic              in_range;
  logic [CentiW-1:0] temp_centi;
  logic [CentiW-1:0] humi_centi;

  reading_t pending_readings[$];
  int       requests_sent;
  int       readings_checked;
  int       in_range_seen;
  int       clamped_seen;
  int       mismatches;
  int       cycle_count;

  humidity_temperature_conversion_unit dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .temp_ticks (temp_ticks),
    .humi_ticks (humi_ticks),
    .done       (done),
    .in_range   (in_range),
    .temp_centi (temp_centi),
    .humi_centi (humi_centi)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  function automatic reading_t convert_reading(logic [TicksW-1:0] t, logic [HumiW-1:0] h);
    longint   tc;
    longint   rh;
    longint   hsum;
    longint   q;
    reading_t r;
    r  = '0;
    tc = longint'(t) - TicksOffset;
    rh = longint'(h);
    if (tc >= 0 && tc <= TcMax) begin
      hsum = RhBase + RhLinear * rh - RhSquare * rh * rh
             + (tc - TcPivot) * (CompBase + CompSlope * rh);
      q = hsum / CentiScale;
      if (q < HumiFloor) q = HumiFloor;
      if (q > HumiCeil) q = HumiCeil;
      r.in_range   = 1'b1;
      r.temp_centi = tc[CentiW-1:0];
      r.humi_centi = q[CentiW-1:0];
    end
    return r;
  endfunction

  // capture requests first, then check any result leaving in the same cycle
  always @(posedge clk) begin
    reading_t want;
    if (!rst && start && !busy) begin
      pending_readings.push_back(convert_reading(temp_ticks, humi_ticks));
      requests_sent++;
    end
    if (!rst && done) begin
      if (pending_readings.size() == 0) begin
        $display("%0t: unexpected result in_range=%0b temp_centi=%0d humi_centi=%0d",
                 $time, in_range, temp_centi, humi_centi);
        mismatches++;
      end else begin
        want = pending_readings.pop_front();
        readings_checked++;
        if (want.in_range) in_range_seen++;
        if (want.in_range && (want.humi_centi == HumiFloor || want.humi_centi == HumiCeil))
          clamped_seen++;
        if (in_range !== want.in_range) begin
          $display("%0t: in_range expected %0b actual %0b", $time, want.in_range, in_range);
          mismatches++;
        end
        if (temp_centi !== want.temp_centi) begin
          $display("%0t: temp_centi expected %0d actual %0d",
                   $time, want.temp_centi, temp_centi);
          mismatches++;
        end
        if (humi_centi !== want.humi_centi) begin
          $display("%0t: humi_centi expected %0d actual %0d",
                   $time, want.humi_centi, humi_centi);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("%0t: timeout with %0d readings outstanding", $time, pending_readings.size());
      $display("humidity_temperature_conversion_unit verification failed");
      $finish;
    end
  end

  task automatic send_request(input logic [TicksW-1:0] t, input logic [HumiW-1:0] h);
    @(negedge clk);
    start      <= 1'b1;
    temp_ticks <= t;
    humi_ticks <= h;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic hold_off(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      start      <= 1'b0;
      temp_ticks <= TicksW'($urandom);
      humi_ticks <= HumiW'($urandom);
    end
  endtask

  task automatic test_temperature_window();
    send_request(14'd0, 12'd2000);
    send_request(14'd4009, 12'd2000);
    send_request(14'd4010, 12'd2000);
    send_request(14'd4011, 12'd0);
    send_request(14'd14010, 12'd2000);
    send_request(14'd14011, 12'd2000);
    send_request(14'd16383, 12'd4095);
    hold_off(3);
    send_request(14'd6510, 12'd1500);
    send_request(14'd9000, 12'd4095);
    send_request(14'd8191, 12'd2730);
  endtask

  task automatic test_humidity_clamp();
    send_request(14'd6510, 12'd0);
    send_request(14'd4010, 12'd0);
    send_request(14'd14010, 12'd0);
    send_request(14'd6510, 12'd4095);
    send_request(14'd14010, 12'd4095);
    send_request(14'd4010, 12'd4095);
    hold_off(2);
    send_request(14'd6510, 12'd60);
    send_request(14'd6510, 12'd3300);
    send_request(14'd12000, 12'd2800);
    send_request(14'd4010, 12'd1);
  endtask

  task automatic test_random_readings(input int count);
    int               sent;
    int               burst;
    logic [TicksW-1:0] t;
    logic [HumiW-1:0]  h;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 24);
      repeat (burst) begin
        case ($urandom_range(0, 9))
          0:       t = TicksW'($urandom);
          1:       t = ($urandom_range(0, 1) != 0) ? TicksW'($urandom_range(3995, 4025))
                                                   : TicksW'($urandom_range(13995, 14025));
          default: t = TicksW'($urandom_range(4010, 14010));
        endcase
        case ($urandom_range(0, 7))
          0:       h = ($urandom_range(0, 1) != 0) ? 12'd0 : 12'd4095;
          1:       h = HumiW'($urandom_range(0, 80));
          default: h = HumiW'($urandom);
        endcase
        send_request(t, h);
        sent++;
      end
      if ($urandom_range(0, 3) != 0) hold_off($urandom_range(1, 7));
    end
  endtask

  initial begin
    rst        = 1'b1;
    start      = 1'b0;
    temp_ticks = '0;
    humi_ticks = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_temperature_window();
    test_humidity_clamp();
    hold_off(4);
    test_random_readings(500);
    hold_off(1);

    while (pending_readings.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("Ran %0d conversion requests, %0d results checked", requests_sent,
             readings_checked);
    $display("  %0d with temperature in range, %0d of those at a humidity clamp",
             in_range_seen, clamped_seen);
    if (mismatches == 0 && pending_readings.size() == 0) begin
      $display("humidity_temperature_conversion_unit verification clean");
    end else begin
      $display("humidity_temperature_conversion_unit verification failed");
    end
    $finish;
  end

endmodule
